/* design/abtt_pkg.sv */
package abtt_pkg;

    localparam int TREE_NODES  = 63;
    localparam int TREE_DEPTH  = 6;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int IDX_W       = 7;
    localparam int LVL_W       = 3;
    localparam int VAL_W       = 8;
    localparam int ORD_W       = 3;
    localparam int STEP_W      = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    localparam logic [ORD_W-1:0] ORD_PRE      = 3'd0;
    localparam logic [ORD_W-1:0] ORD_IN       = 3'd1;
    localparam logic [ORD_W-1:0] ORD_POST     = 3'd2;
    localparam logic [ORD_W-1:0] ORD_MIR_PRE  = 3'd3;
    localparam logic [ORD_W-1:0] ORD_MIR_IN   = 3'd4;
    localparam logic [ORD_W-1:0] ORD_MIR_POST = 3'd5;

    localparam logic [1:0] POS_PRE  = 2'd0;
    localparam logic [1:0] POS_IN   = 2'd1;
    localparam logic [1:0] POS_POST = 2'd2;

    localparam logic [STEP_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STEP_W-1:0] ST_DESC = 2'd1;
    localparam logic [STEP_W-1:0] ST_UP   = 2'd2;
    localparam logic [STEP_W-1:0] ST_BACK = 2'd3;

    localparam logic [1:0] C_START   = 2'd0;
    localparam logic [1:0] C_PRESENT = 2'd1;
    localparam logic [1:0] C_ROOT    = 2'd2;
    localparam logic [1:0] C_FIRST   = 2'd3;

    localparam logic [2:0] IX_HOLD   = 3'd0;
    localparam logic [2:0] IX_ROOT   = 3'd1;
    localparam logic [2:0] IX_FIRST  = 3'd2;
    localparam logic [2:0] IX_SECOND = 3'd3;
    localparam logic [2:0] IX_PARENT = 3'd4;

    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_PRE  = 2'd1;
    localparam logic [1:0] EM_IN   = 2'd2;
    localparam logic [1:0] EM_POST = 2'd3;

    typedef struct packed {
        logic             cmd;
        logic [5:0]       node_index;
        logic [VAL_W-1:0] node_value;
        logic [ORD_W-1:0] order;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] visit_value;
        logic [5:0]       visit_index;
        logic             last;
        logic             empty_res;
    } t_res;

    typedef struct packed {
        logic [2:0] idx_op;
        logic [1:0] emit;
        logic       fin;
    } t_act;

    typedef struct packed {
        logic [1:0]        cond;
        t_act              act_t;
        t_act              act_f;
        logic [STEP_W-1:0] jmp_t;
        logic [STEP_W-1:0] jmp_f;
    } t_uword;

    typedef struct packed {
        logic start;
        logic present;
        logic at_root;
        logic came_first;
    } t_flags;

    // microprogram: one word per step
    function automatic t_uword uprog(input logic [STEP_W-1:0] step);
        t_uword w;
        begin
            unique case (step)
                ST_IDLE: begin
                    w = '{C_START, '{IX_ROOT, EM_NONE, 1'b0}, '{IX_HOLD, EM_NONE, 1'b0},
                          ST_DESC, ST_IDLE};
                end
                ST_DESC: begin
                    w = '{C_PRESENT, '{IX_FIRST, EM_PRE, 1'b0}, '{IX_HOLD, EM_NONE, 1'b0},
                          ST_DESC, ST_UP};
                end
                ST_UP: begin
                    w = '{C_ROOT, '{IX_HOLD, EM_NONE, 1'b1}, '{IX_PARENT, EM_NONE, 1'b0},
                          ST_IDLE, ST_BACK};
                end
                ST_BACK: begin
                    w = '{C_FIRST, '{IX_SECOND, EM_IN, 1'b0}, '{IX_HOLD, EM_POST, 1'b0},
                          ST_DESC, ST_UP};
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* design/array_binary_tree_traversal_unit.sv */
// channel   | ports                     | handshake
// request   | i_start, i_req (t_req)    | taken when i_start and not o_busy
// result    | o_valid, o_res (t_res)    | one-cycle strobe, no back-pressure
//
// A load request is written in the cycle it is taken; o_busy stays low.
// A traversal over n present nodes holds o_busy high through all of its steps:
// per present node one descent step, two return steps and one climb step, plus a
// descent and a climb for each of the n + 1 absent child slots.
// Each node result is held until the next visit so the final one can carry last;
// the final or empty result strobes in the same cycle that o_busy falls.
// Reset (synchronous, active low) marks every node absent at once.
// Results cannot be stalled by the receiver.
module array_binary_tree_traversal_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  abtt_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_valid,
    output abtt_pkg::t_res o_res
);

    abtt_pkg::t_flags flags;
    abtt_pkg::t_act   act;

    abtt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_act   (act),
        .o_busy  (o_busy)
    );

    abtt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .i_busy  (o_busy),
        .i_act   (act),
        .o_flags (flags),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.empty_res) |-> (o_res.last && (o_res.visit_index == '0)))
        else $error("empty result without last");

    a_node_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.empty_res) |-> (o_res.visit_index != '0))
        else $error("node result with index zero");

    a_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_busy)) |-> (o_valid && o_res.last))
        else $error("traversal ended without final result");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |=> !o_valid)
        else $error("result right after final result");

endmodule

/* design/abtt_ram.sv */
module abtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/abtt_seq.sv */
module abtt_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abtt_pkg::t_flags     i_flags,
    output abtt_pkg::t_act       o_act,
    output logic                 o_busy
);

    logic [abtt_pkg::STEP_W-1:0] r_step;
    logic [abtt_pkg::STEP_W-1:0] n_step;
    abtt_pkg::t_uword            uw;
    logic                        cond_hit;

    always_comb begin
        uw = abtt_pkg::uprog(r_step);
        unique case (uw.cond)
            abtt_pkg::C_START:   cond_hit = i_flags.start;
            abtt_pkg::C_PRESENT: cond_hit = i_flags.present;
            abtt_pkg::C_ROOT:    cond_hit = i_flags.at_root;
            abtt_pkg::C_FIRST:   cond_hit = i_flags.came_first;
        endcase
        o_act  = cond_hit ? uw.act_t : uw.act_f;
        n_step = cond_hit ? uw.jmp_t : uw.jmp_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= abtt_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_busy = (r_step != abtt_pkg::ST_IDLE);

endmodule

/* design/abtt_dpath.sv */
module abtt_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  abtt_pkg::t_req   i_req,
    input  logic             i_busy,
    input  abtt_pkg::t_act   i_act,
    output abtt_pkg::t_flags o_flags,
    output logic             o_valid,
    output abtt_pkg::t_res   o_res
);

    logic [abtt_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [abtt_pkg::LVL_W-1:0]       r_lvl, n_lvl;
    logic                             r_mirror;
    logic [1:0]                       r_pos, n_pos;
    logic                             r_first;
    logic [abtt_pkg::STORE_DEPTH-1:0] r_vbits;
    logic                             r_rv;
    logic [abtt_pkg::VAL_W-1:0]       ram_rdata;
    logic [abtt_pkg::VAL_W-1:0]       cur_val;
    logic [abtt_pkg::ADDR_W-1:0]      raddr;
    logic                             accept;
    logic                             wr_en;
    logic                             emit_hit;
    logic                             r_pend_vld;
    logic [abtt_pkg::VAL_W-1:0]       r_pend_val;
    logic [abtt_pkg::ADDR_W-1:0]      r_pend_idx;
    logic                             r_out_vld;
    abtt_pkg::t_res                   r_out;

    assign accept = i_start && !i_busy;
    assign wr_en  = accept && (i_req.cmd == abtt_pkg::CMD_LOAD)
                    && (i_req.node_index != '0)
                    && ({1'b0, i_req.node_index} <= abtt_pkg::IDX_W'(abtt_pkg::TREE_NODES));

    always_comb begin
        unique case (i_act.idx_op)
            abtt_pkg::IX_ROOT: begin
                n_idx = abtt_pkg::IDX_W'(1);
                n_lvl = abtt_pkg::LVL_W'(1);
            end
            abtt_pkg::IX_FIRST: begin
                n_idx = {r_idx[abtt_pkg::IDX_W-2:0], r_mirror};
                n_lvl = r_lvl + abtt_pkg::LVL_W'(1);
            end
            abtt_pkg::IX_SECOND: begin
                n_idx = {r_idx[abtt_pkg::IDX_W-2:0], !r_mirror};
                n_lvl = r_lvl + abtt_pkg::LVL_W'(1);
            end
            abtt_pkg::IX_PARENT: begin
                n_idx = {1'b0, r_idx[abtt_pkg::IDX_W-1:1]};
                n_lvl = r_lvl - abtt_pkg::LVL_W'(1);
            end
            default: begin
                n_idx = r_idx;
                n_lvl = r_lvl;
            end
        endcase
    end

    always_comb begin
        unique case (i_req.order)
            abtt_pkg::ORD_PRE, abtt_pkg::ORD_MIR_PRE: n_pos = abtt_pkg::POS_PRE;
            abtt_pkg::ORD_IN,  abtt_pkg::ORD_MIR_IN:  n_pos = abtt_pkg::POS_IN;
            default:                                  n_pos = abtt_pkg::POS_POST;
        endcase
    end

    assign raddr = n_idx[abtt_pkg::ADDR_W-1:0];

    abtt_ram #(
        .WIDTH (abtt_pkg::VAL_W),
        .DEPTH (abtt_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_req.node_index),
        .i_wdata (i_req.node_value),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_val = r_rv ? ram_rdata : '0;

    assign o_flags.start = accept && (i_req.cmd == abtt_pkg::CMD_RUN)
                           && (i_req.order <= abtt_pkg::ORD_MIR_POST);
    assign o_flags.present = (r_idx <= abtt_pkg::IDX_W'(abtt_pkg::TREE_NODES))
                             && (r_lvl <= abtt_pkg::LVL_W'(abtt_pkg::TREE_DEPTH))
                             && (cur_val != '0);
    assign o_flags.at_root    = (r_idx == abtt_pkg::IDX_W'(1));
    assign o_flags.came_first = r_first;

    assign emit_hit = ((i_act.emit == abtt_pkg::EM_PRE)  && (r_pos == abtt_pkg::POS_PRE))
                   || ((i_act.emit == abtt_pkg::EM_IN)   && (r_pos == abtt_pkg::POS_IN))
                   || ((i_act.emit == abtt_pkg::EM_POST) && (r_pos == abtt_pkg::POS_POST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= abtt_pkg::IDX_W'(1);
            r_lvl      <= abtt_pkg::LVL_W'(1);
            r_vbits    <= '0;
            r_rv       <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_lvl <= n_lvl;
            r_rv  <= r_vbits[raddr];
            if (wr_en) begin
                r_vbits[i_req.node_index] <= 1'b1;
            end
            // one result held back so the final one can carry last
            if (emit_hit) begin
                r_pend_vld <= 1'b1;
                r_out_vld  <= r_pend_vld;
            end else if (i_act.fin) begin
                r_pend_vld <= 1'b0;
                r_out_vld  <= 1'b1;
            end else begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_act.idx_op == abtt_pkg::IX_ROOT) begin
            r_mirror <= (i_req.order >= abtt_pkg::ORD_MIR_PRE);
            r_pos    <= n_pos;
        end
        if (i_act.idx_op == abtt_pkg::IX_PARENT) begin
            r_first <= (r_idx[0] == r_mirror);
        end
        if (emit_hit) begin
            r_pend_val <= cur_val;
            r_pend_idx <= r_idx[abtt_pkg::ADDR_W-1:0];
            r_out      <= '{r_pend_val, r_pend_idx, 1'b0, 1'b0};
        end else if (i_act.fin) begin
            if (r_pend_vld) begin
                r_out <= '{r_pend_val, r_pend_idx, 1'b1, 1'b0};
            end else begin
                r_out <= '{'0, '0, 1'b1, 1'b1};
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

/* bench/tb_array_binary_tree_traversal_unit.sv */
`timescale 1ns / 1ps

module tb_array_binary_tree_traversal_unit;

    localparam int CLK_PERIOD   = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 3 * abtt_pkg::TREE_NODES + 16;
    localparam int RANDOM_ITEMS = 80;

    localparam logic [abtt_pkg::ORD_W-1:0] ORD_SPARE_A = 3'd6;
    localparam logic [abtt_pkg::ORD_W-1:0] ORD_SPARE_B = 3'd7;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    abtt_pkg::t_req i_req;
    logic           o_busy;
    logic           o_valid;
    abtt_pkg::t_res o_res;

    abtt_pkg::t_res             visit_q[$];
    logic [abtt_pkg::VAL_W-1:0] tree_mem[abtt_pkg::STORE_DEPTH];
    int                         fail_cnt;
    int                         sent_cnt;
    int                         idle_cycles;
    int                         next_gap;
    int                         burst_left;
    bit                         start_high;

    array_binary_tree_traversal_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bit node_live(int idx, int level);
        return idx > 0 && idx <= abtt_pkg::TREE_NODES && level <= abtt_pkg::TREE_DEPTH
               && tree_mem[idx] != '0;
    endfunction

    function automatic void walk_tree(int idx, int level, logic [1:0] pos, bit mirror);
        int             first;
        int             second;
        abtt_pkg::t_res r;
        if (!node_live(idx, level)) return;
        first         = mirror ? 2 * idx + 1 : 2 * idx;
        second        = mirror ? 2 * idx : 2 * idx + 1;
        r.visit_value = tree_mem[idx];
        r.visit_index = idx[5:0];
        r.last        = 1'b0;
        r.empty_res   = 1'b0;
        if (pos == abtt_pkg::POS_PRE) visit_q.push_back(r);
        walk_tree(first, level + 1, pos, mirror);
        if (pos == abtt_pkg::POS_IN) visit_q.push_back(r);
        walk_tree(second, level + 1, pos, mirror);
        if (pos == abtt_pkg::POS_POST) visit_q.push_back(r);
    endfunction

    function automatic void predict_req(abtt_pkg::t_req r);
        logic [1:0]     pos;
        bit             mirror;
        abtt_pkg::t_res res;
        if (r.cmd == abtt_pkg::CMD_LOAD) begin
            if (r.node_index != 0 && r.node_index <= abtt_pkg::TREE_NODES)
                tree_mem[r.node_index] = r.node_value;
            return;
        end
        case (r.order)
            abtt_pkg::ORD_PRE: begin
                pos = abtt_pkg::POS_PRE;  mirror = 1'b0;
            end
            abtt_pkg::ORD_IN: begin
                pos = abtt_pkg::POS_IN;   mirror = 1'b0;
            end
            abtt_pkg::ORD_POST: begin
                pos = abtt_pkg::POS_POST; mirror = 1'b0;
            end
            abtt_pkg::ORD_MIR_PRE: begin
                pos = abtt_pkg::POS_PRE;  mirror = 1'b1;
            end
            abtt_pkg::ORD_MIR_IN: begin
                pos = abtt_pkg::POS_IN;   mirror = 1'b1;
            end
            abtt_pkg::ORD_MIR_POST: begin
                pos = abtt_pkg::POS_POST; mirror = 1'b1;
            end
            default: return;
        endcase
        if (!node_live(1, 1)) begin
            res.visit_value = '0;
            res.visit_index = '0;
            res.last        = 1'b1;
            res.empty_res   = 1'b1;
            visit_q.push_back(res);
            return;
        end
        walk_tree(1, 1, pos, mirror);
        res      = visit_q.pop_back();
        res.last = 1'b1;
        visit_q.push_back(res);
    endfunction

    function automatic abtt_pkg::t_req run_req(logic [abtt_pkg::ORD_W-1:0] ord);
        abtt_pkg::t_req r;
        r.cmd        = abtt_pkg::CMD_RUN;
        r.node_index = 6'($urandom);
        r.node_value = 8'($urandom);
        r.order      = ord;
        return r;
    endfunction

    function automatic abtt_pkg::t_req load_req(int idx, int val);
        abtt_pkg::t_req r;
        r.cmd        = abtt_pkg::CMD_LOAD;
        r.node_index = idx[5:0];
        r.node_value = val[abtt_pkg::VAL_W-1:0];
        r.order      = 3'($urandom);
        return r;
    endfunction

    task automatic send_req(abtt_pkg::t_req r);
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        i_req      <= r;
        i_start    <= 1'b1;
        start_high = 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_req(r);
        sent_cnt++;
        if (burst_left > 0) begin
            burst_left--;
            next_gap = 0;
        end else begin
            next_gap = $urandom_range(0, 18);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(4, 12);
        end
        if (next_gap > 0) begin
            i_start    <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    task automatic wait_results();
        if (start_high) begin
            i_start    <= 1'b0;
            start_high = 1'b0;
        end
        do @(posedge i_clk); while (visit_q.size() != 0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        abtt_pkg::t_res exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            if (visit_q.size() == 0) begin
                $error("unexpected result: value %0d index %0d",
                       o_res.visit_value, o_res.visit_index);
                fail_cnt++;
            end else begin
                exp_r = visit_q.pop_front();
                if (o_res.visit_value !== exp_r.visit_value) begin
                    $error("visit_value: expected %0d, got %0d",
                           exp_r.visit_value, o_res.visit_value);
                    fail_cnt++;
                end
                if (o_res.visit_index !== exp_r.visit_index) begin
                    $error("visit_index: expected %0d, got %0d",
                           exp_r.visit_index, o_res.visit_index);
                    fail_cnt++;
                end
                if (o_res.last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_res.last);
                    fail_cnt++;
                end
                if (o_res.empty_res !== exp_r.empty_res) begin
                    $error("empty_res: expected %0d, got %0d",
                           exp_r.empty_res, o_res.empty_res);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid === 1'b1) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_array_binary_tree_traversal_unit failed");
            $finish;
        end
    end

    task automatic test_absent_root();
        int o;
        for (o = 0; o < 8; o++) send_req(run_req(o[abtt_pkg::ORD_W-1:0]));
    endtask

    task automatic test_small_tree();
        int o;
        send_req(load_req(1, 255));
        send_req(load_req(2, 1));
        send_req(load_req(3, 8'h80));
        send_req(load_req(6, 8'h5a));
        send_req(load_req(0, 8'h77));
        for (o = abtt_pkg::ORD_PRE; o <= abtt_pkg::ORD_MIR_POST; o++)
            send_req(run_req(o[abtt_pkg::ORD_W-1:0]));
    endtask

    task automatic test_prune_and_deep();
        send_req(load_req(3, 0));
        send_req(run_req(abtt_pkg::ORD_IN));
        send_req(load_req(3, 8'h33));
        send_req(load_req(7, 8'h07));
        send_req(load_req(15, 8'h0f));
        send_req(load_req(31, 8'h1f));
        send_req(load_req(63, 8'hff));
        send_req(run_req(abtt_pkg::ORD_MIR_POST));
        send_req(run_req(ORD_SPARE_B));
        send_req(run_req(abtt_pkg::ORD_POST));
    endtask

    task automatic test_drain_pause();
        send_req(run_req(abtt_pkg::ORD_MIR_IN));
        wait_results();
        send_req(run_req(ORD_SPARE_A));
        send_req(run_req(abtt_pkg::ORD_PRE));
    endtask

    task automatic test_full_tree();
        int i;
        int o;
        for (i = 1; i <= abtt_pkg::TREE_NODES; i++)
            send_req(load_req(i, $urandom_range(1, 255)));
        for (o = abtt_pkg::ORD_PRE; o <= abtt_pkg::ORD_MIR_POST; o++)
            send_req(run_req(o[abtt_pkg::ORD_W-1:0]));
    endtask

    task automatic test_random_trees();
        int stop_at;
        int n;
        int k;
        int i;
        int idx;
        int val;
        int cands[$];
        stop_at = sent_cnt + RANDOM_ITEMS;
        while (sent_cnt < stop_at) begin
            if (tree_mem[1] == '0 && $urandom_range(0, 3) != 0)
                send_req(load_req(1, $urandom_range(1, 255)));
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                cands.delete();
                for (i = 1; i < 32; i++) if (tree_mem[i] != '0) cands.push_back(i);
                if (cands.size() == 0 || $urandom_range(0, 3) == 0) begin
                    idx = $urandom_range(0, 63);
                end else begin
                    idx = 2 * cands[$urandom_range(0, cands.size() - 1)] + $urandom_range(0, 1);
                end
                val = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
                send_req(load_req(idx, val));
            end
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) send_req(run_req(3'($urandom)));
            if ($urandom_range(0, 7) == 0) wait_results();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_req      = '0;
        sent_cnt   = 0;
        next_gap   = 0;
        burst_left = 0;
        start_high = 1'b0;
        foreach (tree_mem[i]) tree_mem[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_absent_root();
        test_small_tree();
        test_prune_and_deep();
        test_drain_pause();
        test_full_tree();
        test_random_trees();

        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_array_binary_tree_traversal_unit passed");
        end else begin
            $display("tb_array_binary_tree_traversal_unit failed");
        end
        $finish;
    end

endmodule
